[sv/pss_pkg.sv]
package pss_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int LEVEL_W    = 7;
	localparam int FILT_W     = 20;
	localparam int CAL_W      = 12;
	localparam int DB_W       = 8;
	localparam int ALPHA_W    = 9;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int AVG_TAPS   = 10;
	localparam int CNT_W      = $clog2(AVG_TAPS + 1);
	localparam int POS_W      = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int SUM_W      = $clog2(AVG_TAPS * SAMPLE_MAX + 1);

	localparam int DIV_N_W    = 27;
	localparam int DIV_Q_W    = 12;
	localparam int DIV_STEP_W = 4;
	localparam int AVG_Q_W    = SAMPLE_W;
	localparam int SCALE_Q_W  = LEVEL_W;

	localparam int MUL_W      = FILT_W + ALPHA_W;
	localparam int ACC_W      = MUL_W + 1;
	localparam int DIST_W     = FILT_W + 2;
	localparam int SPAN_W     = CAL_W + 1;

	localparam int ALPHA_ONE  = 256;
	localparam int ROUND_HALF = 128;
	localparam int LEVEL_MAX  = 127;

	localparam logic [CAL_W-1:0]   CAL_LOW_RST   = 12'd156;
	localparam logic [CAL_W-1:0]   CAL_HIGH_RST  = 12'd1609;
	localparam logic [DB_W-1:0]    DEAD_BAND_RST = 8'd1;
	localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd77;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_LOW   = 2'd0,
		CFG_CAL_HIGH  = 2'd1,
		CFG_DEAD_BAND = 2'd2,
		CFG_ALPHA     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                cable_present;
	} pss_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_out;
		logic               send_now;
		logic [FILT_W-1:0]  smoothed_value;
	} pss_out_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic update;
	} avg_ctl_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
		logic [DIV_N_W-1:0]    dividend;
		logic [DIV_N_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_Q_W-1:0] quotient;
	} div_rsp_t;

endpackage

[sv/pss_avg.sv]
module pss_avg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pss_pkg::avg_ctl_t              ctl,
	input  logic [pss_pkg::SAMPLE_W-1:0]   sample,
	output logic [pss_pkg::SUM_W-1:0]      sum,
	output logic [pss_pkg::CNT_W-1:0]      count
);

	logic [pss_pkg::SAMPLE_W-1:0] ring_mem [pss_pkg::AVG_TAPS];
	logic [pss_pkg::SAMPLE_W-1:0] old_q;
	logic [pss_pkg::SAMPLE_W-1:0] smp_q;
	logic [pss_pkg::POS_W-1:0]    pos_q;
	logic [pss_pkg::SUM_W-1:0]    sum_q;
	logic [pss_pkg::CNT_W-1:0]    count_q;
	logic                         warm;

	assign warm = count_q < pss_pkg::CNT_W'(pss_pkg::AVG_TAPS);

	// history ring, old entry read as the word comes in
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			old_q <= ring_mem[pos_q];
			smp_q <= sample;
		end
		if (ctl.update) begin
			ring_mem[pos_q] <= smp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctl.update) begin
			if (warm) begin
				sum_q   <= sum_q + pss_pkg::SUM_W'(smp_q);
				count_q <= count_q + 1'b1;
			end else begin
				sum_q <= sum_q - pss_pkg::SUM_W'(old_q) + pss_pkg::SUM_W'(smp_q);
			end
			pos_q <= (pos_q == pss_pkg::POS_W'(pss_pkg::AVG_TAPS - 1)) ? '0 : pos_q + 1'b1;
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

endmodule

[sv/pss_div.sv]
module pss_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pss_pkg::div_req_t req,
	output pss_pkg::div_rsp_t rsp
);

	logic [pss_pkg::DIV_N_W-1:0]    rem_q;
	logic [pss_pkg::DIV_N_W-1:0]    dsh_q;
	logic [pss_pkg::DIV_Q_W-1:0]    quo_q;
	logic [pss_pkg::DIV_STEP_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic                           fit;

	assign fit = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pss_pkg::DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, divisor arrives aligned to the top quotient bit
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fit) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[pss_pkg::DIV_Q_W-2:0], fit};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("division started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("division done while still busy");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0))
		else $error("division busy with no steps left");

endmodule

[sv/pedal_sample_smoother_scaler.sv]
// sequencing: with the cable present a word runs through the running sum, the average
// division, the filter and the scaling, whose division is skipped when it is not needed;
// the divider is shared (12 steps for the average, 7 for the scaling); with the cable absent
// the word goes straight to output; a new word is taken only once the last result is registered
// reset: control, running sum, fill count, filter and last sent level cleared, calibration
// registers to defaults; history ring contents undefined, no clearing pass
module pedal_sample_smoother_scaler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pss_pkg::pss_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pss_pkg::pss_out_t                out_data,
	input  logic                             cfg_we,
	input  logic [pss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pss_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b000000000001,
		ST_SUM       = 12'b000000000010,
		ST_DIVA_GO   = 12'b000000000100,
		ST_DIVA_WAIT = 12'b000000001000,
		ST_MUL_A     = 12'b000000010000,
		ST_MUL_B     = 12'b000000100000,
		ST_FILT      = 12'b000001000000,
		ST_PREP      = 12'b000010000000,
		ST_DECIDE    = 12'b000100000000,
		ST_DIVS_WAIT = 12'b001000000000,
		ST_DEAD      = 12'b010000000000,
		ST_OUT       = 12'b100000000000
	} state_t;

	state_t state_q;
	state_t state_d;

	logic [pss_pkg::CAL_W-1:0]   cal_low_q;
	logic [pss_pkg::CAL_W-1:0]   cal_high_q;
	logic [pss_pkg::DB_W-1:0]    dead_band_q;
	logic [pss_pkg::ALPHA_W-1:0] alpha_q;

	logic [pss_pkg::FILT_W-1:0]  filter_q;
	logic [pss_pkg::LEVEL_W-1:0] last_q;
	logic [pss_pkg::AVG_Q_W-1:0] avg_q;
	logic [pss_pkg::MUL_W-1:0]   prod_q;
	logic [pss_pkg::ACC_W-1:0]   term_q;
	logic signed [pss_pkg::DIST_W-1:0] dist_q;
	logic signed [pss_pkg::SPAN_W-1:0] span_q;
	logic [pss_pkg::LEVEL_W-1:0] level_q;
	logic                        send_q;
	logic                        out_valid_q;
	pss_pkg::pss_out_t           out_data_q;

	pss_pkg::avg_ctl_t           avg_ctl;
	pss_pkg::div_req_t           div_req;
	pss_pkg::div_rsp_t           div_rsp;
	logic [pss_pkg::SUM_W-1:0]   sum;
	logic [pss_pkg::CNT_W-1:0]   count;

	logic [pss_pkg::ALPHA_W-1:0] alpha_sat;
	logic [pss_pkg::FILT_W-1:0]  mul_x;
	logic [pss_pkg::ALPHA_W-1:0] mul_y;
	logic [pss_pkg::MUL_W-1:0]   mul_p;
	logic [pss_pkg::ACC_W-1:0]   acc;

	logic signed [pss_pkg::DIST_W-1:0] dist_raw;
	logic signed [pss_pkg::SPAN_W-1:0] span_raw;
	logic                        span_zero;
	logic                        dist_pos;
	logic                        dist_full;
	logic                        scale_div;
	logic [pss_pkg::LEVEL_W-1:0] level_dec;
	logic [pss_pkg::DIV_N_W-1:0] dist_ext;
	logic [pss_pkg::DIV_N_W-1:0] span_ext;

	logic [pss_pkg::LEVEL_W-1:0] diff;
	logic                        send_d;
	logic                        out_free;

	pss_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (avg_ctl),
		.sample (in_data.sample),
		.sum    (sum),
		.count  (count)
	);

	pss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// iir weights
	assign alpha_sat = (alpha_q > pss_pkg::ALPHA_W'(pss_pkg::ALPHA_ONE)) ?
		pss_pkg::ALPHA_W'(pss_pkg::ALPHA_ONE) : alpha_q;
	assign mul_x = (state_q == ST_MUL_A) ? pss_pkg::FILT_W'(avg_q) : filter_q;
	assign mul_y = (state_q == ST_MUL_A) ? alpha_sat :
		pss_pkg::ALPHA_W'(pss_pkg::ALPHA_ONE) - alpha_sat;
	assign mul_p = pss_pkg::MUL_W'(mul_x) * pss_pkg::MUL_W'(mul_y);
	assign acc   = term_q + pss_pkg::ACC_W'(prod_q) + pss_pkg::ACC_W'(pss_pkg::ROUND_HALF);

	// scaling against calibration
	assign dist_raw = $signed({2'b00, filter_q}) -
		$signed({2'b00, cal_low_q, {pss_pkg::FRAC_W{1'b0}}});
	assign span_raw = $signed({1'b0, cal_high_q}) - $signed({1'b0, cal_low_q});

	assign span_zero = (span_q == '0);
	assign dist_pos  = (dist_q > 0);
	assign dist_full = dist_q[pss_pkg::FILT_W:0] >=
		{1'b0, span_q[pss_pkg::CAL_W-1:0], {pss_pkg::FRAC_W{1'b0}}};
	assign scale_div = !span_zero && dist_pos && !dist_full;
	assign level_dec = dist_pos ? pss_pkg::LEVEL_W'(pss_pkg::LEVEL_MAX) : '0;
	assign dist_ext  = pss_pkg::DIV_N_W'(dist_q[pss_pkg::FILT_W:0]);
	assign span_ext  = pss_pkg::DIV_N_W'(span_q[pss_pkg::CAL_W-1:0]);

	// dead band
	assign diff   = (level_q >= last_q) ? level_q - last_q : last_q - level_q;
	assign send_d = pss_pkg::DB_W'(diff) >= dead_band_q;

	always_comb begin
		state_d = state_q;
		avg_ctl = '0;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.cable_present) begin
						avg_ctl.load = 1'b1;
						state_d      = ST_SUM;
					end else begin
						avg_ctl.clear = 1'b1;
						state_d       = ST_OUT;
					end
				end
			end
			ST_SUM: begin
				avg_ctl.update = 1'b1;
				state_d        = ST_DIVA_GO;
			end
			ST_DIVA_GO: begin
				div_req.start    = 1'b1;
				div_req.steps    = pss_pkg::DIV_STEP_W'(pss_pkg::AVG_Q_W);
				div_req.dividend = pss_pkg::DIV_N_W'(sum);
				div_req.divisor  = pss_pkg::DIV_N_W'(count) << (pss_pkg::AVG_Q_W - 1);
				state_d          = ST_DIVA_WAIT;
			end
			ST_DIVA_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				state_d = ST_FILT;
			end
			ST_FILT: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (scale_div) begin
					// (127 d + 128 span) / (256 span)
					div_req.start    = 1'b1;
					div_req.steps    = pss_pkg::DIV_STEP_W'(pss_pkg::SCALE_Q_W);
					div_req.dividend = (dist_ext << pss_pkg::SCALE_Q_W) - dist_ext +
						(span_ext << pss_pkg::SCALE_Q_W);
					div_req.divisor  = span_ext << (pss_pkg::FRAC_W + pss_pkg::SCALE_Q_W - 1);
					state_d          = ST_DIVS_WAIT;
				end else begin
					state_d = ST_DEAD;
				end
			end
			ST_DIVS_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_DEAD;
				end
			end
			ST_DEAD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			filter_q    <= '0;
			last_q      <= '0;
			cal_low_q   <= pss_pkg::CAL_LOW_RST;
			cal_high_q  <= pss_pkg::CAL_HIGH_RST;
			dead_band_q <= pss_pkg::DEAD_BAND_RST;
			alpha_q     <= pss_pkg::ALPHA_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && in_valid && !in_data.cable_present) begin
				filter_q <= '0;
				last_q   <= '0;
			end
			if (state_q == ST_FILT) begin
				filter_q <= acc[pss_pkg::FILT_W+pss_pkg::FRAC_W-1:pss_pkg::FRAC_W];
			end
			if (state_q == ST_DEAD && send_d) begin
				last_q <= level_q;
			end
			if (cfg_we) begin
				unique case (pss_pkg::cfg_reg_t'(cfg_index))
					pss_pkg::CFG_CAL_LOW:   cal_low_q   <= cfg_data[pss_pkg::CAL_W-1:0];
					pss_pkg::CFG_CAL_HIGH:  cal_high_q  <= cfg_data[pss_pkg::CAL_W-1:0];
					pss_pkg::CFG_DEAD_BAND: dead_band_q <= cfg_data[pss_pkg::DB_W-1:0];
					pss_pkg::CFG_ALPHA:     alpha_q     <= cfg_data[pss_pkg::ALPHA_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid && !in_data.cable_present) begin
			level_q <= '0;
			send_q  <= 1'b0;
		end
		if (state_q == ST_DIVA_WAIT && div_rsp.done) begin
			avg_q <= div_rsp.quotient[pss_pkg::AVG_Q_W-1:0];
		end
		if (state_q == ST_MUL_A) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_MUL_B) begin
			term_q <= pss_pkg::ACC_W'({prod_q, {pss_pkg::FRAC_W{1'b0}}});
			prod_q <= mul_p;
		end
		if (state_q == ST_PREP) begin
			if (span_raw[pss_pkg::SPAN_W-1]) begin
				dist_q <= -dist_raw;
				span_q <= -span_raw;
			end else begin
				dist_q <= dist_raw;
				span_q <= span_raw;
			end
		end
		if (state_q == ST_DECIDE && !scale_div) begin
			level_q <= span_zero ? level_dec : (dist_pos ? level_dec : '0);
		end
		if (state_q == ST_DIVS_WAIT && div_rsp.done) begin
			level_q <= div_rsp.quotient[pss_pkg::LEVEL_W-1:0];
		end
		if (state_q == ST_DEAD) begin
			send_q <= send_d;
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q.level_out      <= level_q;
			out_data_q.send_now       <= send_q;
			out_data_q.smoothed_value <= filter_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("word accepted while previous word still in work");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIVA_WAIT || state_q == ST_DIVS_WAIT))
		else $error("division result with no wait pending");

	a_scale_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVS_WAIT) |-> (dist_q > 0 && span_q > 0))
		else $error("scaling division with non-positive operands");

endmodule

[test/pedal_sample_smoother_scaler_test.sv]
`timescale 1ns / 100ps

module pedal_sample_smoother_scaler_test;

	import pss_pkg::*;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pss_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	pss_out_t              out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pedal_sample_smoother_scaler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state and its copy of the registers
	int unsigned tap_hist [AVG_TAPS];
	int unsigned tap_slot = 0;
	int unsigned tap_sum = 0;
	int unsigned tap_fill = 0;
	int unsigned filt_q12_8 = 0;
	int unsigned last_level_sent = 0;
	int unsigned cal_lo_q = CAL_LOW_RST;
	int unsigned cal_hi_q = CAL_HIGH_RST;
	int unsigned dband_q = DEAD_BAND_RST;
	int unsigned alpha_q = ALPHA_RST;

	pss_in_t  words_pending [$];
	pss_out_t levels_due [$];
	pss_out_t due_word;
	int       mismatch_count = 0;
	int       pedal_pos = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       stall_mode = 0;
	int       stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t: %s", $time, msg);
	endtask

	function automatic int unsigned level_of(input longint f);
		longint lo;
		longint hi;
		longint num;
		longint den;
		lo = cal_lo_q;
		hi = cal_hi_q;
		if (hi == lo)
			return (f > lo * 256) ? LEVEL_MAX : 0;
		num = (f - lo * 256) * 127;
		den = (hi - lo) * 256;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num <= 0)
			return 0;
		if (num >= 127 * den)
			return LEVEL_MAX;
		return int'((2 * num + den) / (2 * den));
	endfunction

	function automatic pss_out_t smooth_and_scale(input pss_in_t w);
		pss_out_t     r;
		int unsigned  slot;
		int unsigned  avg;
		int unsigned  a;
		int unsigned  lvl;
		int unsigned  diff;
		longint unsigned acc;
		r = '0;
		if (!w.cable_present) begin
			tap_sum = 0;
			tap_fill = 0;
			filt_q12_8 = 0;
			last_level_sent = 0;
			return r;
		end
		slot = tap_slot % AVG_TAPS;
		if (tap_fill < AVG_TAPS) begin
			tap_sum += w.sample;
			tap_fill++;
		end else begin
			tap_sum = tap_sum - tap_hist[slot] + w.sample;
		end
		tap_hist[slot] = w.sample;
		tap_slot = (slot + 1) % AVG_TAPS;
		avg = tap_sum / tap_fill;
		a = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		acc = longint'(a) * (longint'(avg) << FRAC_W)
			+ longint'(ALPHA_ONE - a) * filt_q12_8 + ROUND_HALF;
		filt_q12_8 = int'(acc >> FRAC_W) & 32'hFFFFF;
		lvl = level_of(filt_q12_8);
		diff = (lvl > last_level_sent) ? lvl - last_level_sent : last_level_sent - lvl;
		if (diff >= dband_q) begin
			r.send_now = 1'b1;
			last_level_sent = lvl;
		end
		r.level_out = lvl[LEVEL_W-1:0];
		r.smoothed_value = filt_q12_8[FILT_W-1:0];
		return r;
	endfunction

	// mostly a pedal moving about with the cable in, now and then a jump or an unplug
	function automatic pss_in_t pedal_word();
		pss_in_t w;
		int      pick;
		int      step;
		pick = $urandom_range(0, 99);
		step = int'($urandom_range(0, 160)) - 80;
		w.cable_present = 1'b1;
		if (pick < 4) begin
			w.cable_present = 1'b0;
			pedal_pos = $urandom_range(0, SAMPLE_MAX);
		end else if (pick < 30) begin
			pedal_pos = $urandom_range(0, SAMPLE_MAX);
		end else if (pick < 36) begin
			pedal_pos = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
		end else begin
			pedal_pos += step;
			if (pedal_pos < 0)
				pedal_pos = 0;
			if (pedal_pos > SAMPLE_MAX)
				pedal_pos = SAMPLE_MAX;
		end
		w.sample = pedal_pos[SAMPLE_W-1:0];
		return w;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_CAL_LOW:   cal_lo_q = val;
			CFG_CAL_HIGH:  cal_hi_q = val;
			CFG_DEAD_BAND: dband_q = val[DB_W-1:0];
			CFG_ALPHA:     alpha_q = val[ALPHA_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		int n;
		n = 0;
		@(negedge clk);
		while (words_pending.size() != 0 || in_valid)
			@(negedge clk);
		while (levels_due.size() != 0 && n < 5000) begin
			n++;
			@(negedge clk);
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
			input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] al, input int n);
		wait_idle();
		write_reg(CFG_CAL_LOW, lo);
		write_reg(CFG_CAL_HIGH, hi);
		write_reg(CFG_DEAD_BAND, db);
		write_reg(CFG_ALPHA, al);
		@(negedge clk);
		repeat (n) words_pending.push_back(pedal_word());
	endtask

	// sender: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (words_pending.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= words_pending.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 16);
					gap_left <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern switching between free running, random, heavy and periodic stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				stall_left <= $urandom_range(50, 300);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= $urandom_range(0, 1);
				2:       out_ready <= $urandom_range(0, 7) == 0;
				default: out_ready <= (stall_left % 16) < 5;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				levels_due.push_back(smooth_and_scale(in_data));
			if (out_valid && out_ready) begin
				if (levels_due.size() == 0) begin
					report_mismatch("result word with nothing outstanding");
				end else begin
					due_word = levels_due.pop_front();
					if (out_data.level_out !== due_word.level_out)
						report_mismatch($sformatf("level_out %0d, wanted %0d",
							out_data.level_out, due_word.level_out));
					if (out_data.send_now !== due_word.send_now)
						report_mismatch($sformatf("send_now %0b, wanted %0b",
							out_data.send_now, due_word.send_now));
					if (out_data.smoothed_value !== due_word.smoothed_value)
						report_mismatch($sformatf("smoothed_value %0h, wanted %0h",
							out_data.smoothed_value, due_word.smoothed_value));
				end
			end
		end
	end

	initial begin
		pss_in_t w;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// warm-up past a full ring, then the low end, then unplug and replug
		w.cable_present = 1'b1;
		w.sample = SAMPLE_MAX;
		repeat (12) words_pending.push_back(w);
		w.sample = 0;
		repeat (3) words_pending.push_back(w);
		w.cable_present = 1'b0;
		w.sample = SAMPLE_MAX;
		words_pending.push_back(w);
		w.sample = 0;
		words_pending.push_back(w);
		w.cable_present = 1'b1;
		w.sample = 12'd2048;
		words_pending.push_back(w);
		w.sample = 12'd1;
		words_pending.push_back(w);
		repeat (200) words_pending.push_back(pedal_word());

		run_phase(12'd0, 12'd4095, 12'd1, 12'd77, 150);
		run_phase(12'd4095, 12'd0, 12'd0, 12'd256, 150);
		run_phase(12'd2000, 12'd2000, 12'd3, 12'd128, 120);
		run_phase(12'd0, 12'd0, 12'd0, 12'd511, 120);
		run_phase(12'd4095, 12'd4095, 12'd255, 12'd300, 120);
		run_phase(12'd100, 12'd4000, 12'd2, 12'd0, 100);
		run_phase(12'd1000, 12'd1100, 12'd1, 12'd200, 150);
		run_phase(12'd3000, 12'd500, 12'd5, 12'd1, 150);
		repeat (5)
			run_phase(12'($urandom_range(0, SAMPLE_MAX)), 12'($urandom_range(0, SAMPLE_MAX)),
				{4'($urandom), 8'($urandom_range(0, 12))},
				{3'($urandom), 9'($urandom_range(0, 511))}, 120);

		wait_idle();
		if (levels_due.size() != 0)
			report_mismatch($sformatf("%0d result words never came", levels_due.size()));
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
